// ===== src/wfd_pkg.sv =====
// ----------------------------------------------------------------------------
// wfd_pkg
// Shared types and constants for the WebSocket frame deframer and unmasker.
// ----------------------------------------------------------------------------
package wfd_pkg;

  // parse phase of the receive stream
  typedef enum logic [2:0] {
    PH_HDR0    = 3'd0,
    PH_HDR1    = 3'd1,
    PH_EXTLEN  = 3'd2,
    PH_KEY     = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_ERROR   = 3'd5
  } phase_t;

  // result kinds carried on the output tuser
  typedef enum logic [1:0] {
    EV_DATA  = 2'd0,
    EV_EMPTY = 2'd1,
    EV_ERROR = 2'd2
  } event_t;

  localparam int unsigned LEN_W     = 64;
  localparam int unsigned FIELDS_W  = 8 + 4 + 1 + LEN_W;
  localparam int unsigned TDATA_W   = ((FIELDS_W + 7) / 8) * 8;
  localparam int unsigned PAD_W     = TDATA_W - FIELDS_W;

  localparam logic [6:0] LEN7_EXT16 = 7'd126;
  localparam logic [6:0] LEN7_EXT64 = 7'd127;
  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;

endpackage

// ===== src/websocket_frame_deframer_unmask.sv =====
// ----------------------------------------------------------------------------
// websocket_frame_deframer_unmask
// Receive-side WebSocket frame parser: header decode, length decode, unmask.
// ----------------------------------------------------------------------------
// Takes one raw byte per word on the input stream and produces at most one
// word per input byte: a payload byte XORed with the masking key, one
// empty-frame word for a zero-length frame, or one error word for a frame
// whose mask bit is clear, after which every byte is dropped until reset.
// A new byte is taken on every clock in which the output register is empty
// or being read; throughput is one byte per cycle unless m_tready stalls the
// output register, which is refilled in the same cycle it is read. The result
// word is registered and appears in the cycle after its byte is accepted.
module websocket_frame_deframer_unmask (
  input  logic                        clk,
  input  logic                        rst,
  // input stream: [7:0] data_byte
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [7:0]                  s_tdata,
  // output stream
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // [7:0] payload_byte, [11:8] opcode, [12] final_fragment,
  // [76:13] frame_length, [79:77] zero
  output logic [wfd_pkg::TDATA_W-1:0] m_tdata,
  // [1:0] event_res
  output logic [1:0]                  m_tuser,
  // last_of_frame
  output logic                        m_tlast
);
  import wfd_pkg::*;

  // parser state
  phase_t             phase, phase_next;
  logic [3:0]         ext_bytes_left, ext_bytes_left_next;
  logic [LEN_W-1:0]   length_accum, length_accum_next;
  logic [31:0]        key_bytes, key_bytes_next;
  logic [1:0]         key_count, key_count_next;
  logic [LEN_W-1:0]   bytes_remaining, bytes_remaining_next;
  logic [1:0]         key_phase, key_phase_next;
  logic               fin_flag, fin_flag_next;
  logic [3:0]         frame_opcode, frame_opcode_next;

  // result register
  logic               out_valid;
  event_t             out_event;
  logic [7:0]         out_payload;
  logic [3:0]         out_opcode;
  logic               out_fin;
  logic [LEN_W-1:0]   out_length;
  logic               out_last;

  // result of the byte being accepted
  logic               res_valid;
  event_t             res_event;
  logic [7:0]         res_payload;
  logic [LEN_W-1:0]   res_length;
  logic               res_last;

  logic               accept;
  logic [7:0]         key_sel;

  assign s_tready = !out_valid || m_tready;
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    unique case (key_phase)
      2'd0:    key_sel = key_bytes[31:24];
      2'd1:    key_sel = key_bytes[23:16];
      2'd2:    key_sel = key_bytes[15:8];
      default: key_sel = key_bytes[7:0];
    endcase
  end

  always_comb begin
    phase_next           = phase;
    ext_bytes_left_next  = ext_bytes_left;
    length_accum_next    = length_accum;
    key_bytes_next       = key_bytes;
    key_count_next       = key_count;
    bytes_remaining_next = bytes_remaining;
    key_phase_next       = key_phase;
    fin_flag_next        = fin_flag;
    frame_opcode_next    = frame_opcode;
    res_valid            = 1'b0;
    res_event            = EV_DATA;
    res_payload          = 8'd0;
    res_length           = '0;
    res_last             = 1'b0;

    unique case (phase)
      PH_HDR0: begin
        fin_flag_next     = s_tdata[7];
        frame_opcode_next = s_tdata[3:0];
        phase_next        = PH_HDR1;
      end
      PH_HDR1: begin
        if (!s_tdata[7]) begin
          phase_next = PH_ERROR;
          res_valid  = 1'b1;
          res_event  = EV_ERROR;
        end else begin
          key_bytes_next = '0;
          key_count_next = '0;
          if (s_tdata[6:0] == LEN7_EXT16) begin
            length_accum_next   = '0;
            ext_bytes_left_next = EXT16_BYTES;
            phase_next          = PH_EXTLEN;
          end else if (s_tdata[6:0] == LEN7_EXT64) begin
            length_accum_next   = '0;
            ext_bytes_left_next = EXT64_BYTES;
            phase_next          = PH_EXTLEN;
          end else begin
            length_accum_next   = {{(LEN_W-7){1'b0}}, s_tdata[6:0]};
            ext_bytes_left_next = '0;
            phase_next          = PH_KEY;
          end
        end
      end
      PH_EXTLEN: begin
        // big-endian: shift in from the low end
        length_accum_next   = {length_accum[LEN_W-9:0], s_tdata};
        ext_bytes_left_next = ext_bytes_left - 4'd1;
        if (ext_bytes_left == 4'd1) begin
          phase_next = PH_KEY;
        end
      end
      PH_KEY: begin
        key_bytes_next = {key_bytes[23:0], s_tdata};
        if (key_count == 2'd3) begin
          key_count_next       = '0;
          key_phase_next       = '0;
          bytes_remaining_next = length_accum;
          if (length_accum == '0) begin
            phase_next = PH_HDR0;
            res_valid  = 1'b1;
            res_event  = EV_EMPTY;
            res_last   = 1'b1;
          end else begin
            phase_next = PH_PAYLOAD;
          end
        end else begin
          key_count_next = key_count + 2'd1;
        end
      end
      PH_PAYLOAD: begin
        key_phase_next       = key_phase + 2'd1;
        bytes_remaining_next = bytes_remaining - 1'b1;
        res_valid            = 1'b1;
        res_event            = EV_DATA;
        res_payload          = s_tdata ^ key_sel;
        res_length           = length_accum;
        res_last             = (bytes_remaining == {{(LEN_W-1){1'b0}}, 1'b1});
        if (res_last) begin
          phase_next = PH_HDR0;
        end
      end
      // error phase and unused codes swallow every byte
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HDR0;
      ext_bytes_left  <= '0;
      length_accum    <= '0;
      key_bytes       <= '0;
      key_count       <= '0;
      bytes_remaining <= '0;
      key_phase       <= '0;
      fin_flag        <= 1'b0;
      frame_opcode    <= '0;
    end else if (accept) begin
      phase           <= phase_next;
      ext_bytes_left  <= ext_bytes_left_next;
      length_accum    <= length_accum_next;
      key_bytes       <= key_bytes_next;
      key_count       <= key_count_next;
      bytes_remaining <= bytes_remaining_next;
      key_phase       <= key_phase_next;
      fin_flag        <= fin_flag_next;
      frame_opcode    <= frame_opcode_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s_tready) begin
      out_valid <= accept && res_valid;
    end
  end

  // opcode and FIN come from the frame state before this byte's update
  always_ff @(posedge clk) begin
    if (accept && res_valid) begin
      out_event   <= res_event;
      out_payload <= res_payload;
      out_opcode  <= frame_opcode;
      out_fin     <= fin_flag;
      out_length  <= res_length;
      out_last    <= res_last;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{PAD_W{1'b0}}, out_length, out_fin, out_opcode, out_payload};
  assign m_tuser  = out_event;
  assign m_tlast  = out_last;

endmodule

// ===== tb/websocket_frame_deframer_unmask_tb.sv =====
// ----------------------------------------------------------------------------
// websocket_frame_deframer_unmask_tb
// Self-checking bench for the WebSocket receive deframer and unmasker.
// ----------------------------------------------------------------------------
// Feeds masked frames with 7-bit, 16-bit and 64-bit length encodings, empty
// frames and random payloads. A scoreboard class tracks the parse state of
// the byte stream, predicts every output word, and compares each accepted
// word field by field with the oldest prediction. Both stream sides idle at
// random. The run closes with one unmasked frame and trailing bytes, which
// must give a single error word and nothing after it.
module websocket_frame_deframer_unmask_tb;
  import wfd_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 200000;
  localparam int unsigned RAND_BYTES   = 500;
  localparam int unsigned CALM_AFTER   = 400;
  localparam int unsigned TAIL_CYCLES  = 8;

  typedef enum int {
    ENC_LEN7  = 0,
    ENC_LEN16 = 1,
    ENC_LEN64 = 2
  } len_enc_t;

  typedef struct {
    event_t      ev;
    logic [7:0]  pb;
    logic [3:0]  opc;
    logic        fin;
    logic [63:0] len;
    logic        last;
  } unmask_res_t;

  class frame_scoreboard;
    phase_t      phase;
    logic [3:0]  ext_left;
    logic [63:0] len_acc;
    logic [31:0] key;
    logic [1:0]  key_cnt;
    logic [63:0] remaining;
    logic [1:0]  key_idx;
    logic        fin;
    logic [3:0]  opc;
    unmask_res_t expected_q[$];
    int unsigned mismatches;

    function new();
      phase      = PH_HDR0;
      ext_left   = '0;
      len_acc    = '0;
      key        = '0;
      key_cnt    = '0;
      remaining  = '0;
      key_idx    = '0;
      fin        = 1'b0;
      opc        = '0;
      mismatches = 0;
    endfunction

    function void push(event_t ev, logic [7:0] pb, logic [63:0] len, logic last);
      unmask_res_t r;
      r.ev   = ev;
      r.pb   = pb;
      r.opc  = opc;
      r.fin  = fin;
      r.len  = len;
      r.last = last;
      expected_q.push_back(r);
    endfunction

    // one accepted input word
    function void note_byte(logic [7:0] b);
      logic [7:0] k;
      case (phase)
        PH_HDR0: begin
          fin   = b[7];
          opc   = b[3:0];
          phase = PH_HDR1;
        end
        PH_HDR1: begin
          if (!b[7]) begin
            phase = PH_ERROR;
            push(EV_ERROR, 8'h00, 64'd0, 1'b0);
          end else begin
            key     = '0;
            key_cnt = '0;
            if (b[6:0] == LEN7_EXT16) begin
              len_acc  = '0;
              ext_left = EXT16_BYTES;
              phase    = PH_EXTLEN;
            end else if (b[6:0] == LEN7_EXT64) begin
              len_acc  = '0;
              ext_left = EXT64_BYTES;
              phase    = PH_EXTLEN;
            end else begin
              len_acc  = {57'd0, b[6:0]};
              ext_left = '0;
              phase    = PH_KEY;
            end
          end
        end
        PH_EXTLEN: begin
          len_acc  = {len_acc[55:0], b};
          ext_left = ext_left - 4'd1;
          if (ext_left == 4'd0) phase = PH_KEY;
        end
        PH_KEY: begin
          key = {key[23:0], b};
          if (key_cnt == 2'd3) begin
            key_cnt   = '0;
            key_idx   = '0;
            remaining = len_acc;
            if (len_acc == 64'd0) begin
              phase = PH_HDR0;
              push(EV_EMPTY, 8'h00, 64'd0, 1'b1);
            end else begin
              phase = PH_PAYLOAD;
            end
          end else begin
            key_cnt = key_cnt + 2'd1;
          end
        end
        PH_PAYLOAD: begin
          // first key byte sits in the top lane
          k         = key[(3 - int'(key_idx)) * 8 +: 8];
          key_idx   = key_idx + 2'd1;
          remaining = remaining - 64'd1;
          if (remaining == 64'd0) phase = PH_HDR0;
          push(EV_DATA, b ^ k, len_acc, remaining == 64'd0);
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic [TDATA_W-1:0] d, logic [1:0] u, logic l);
      unmask_res_t e;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected output word tuser=%0d tdata=%h tlast=%b", u, d, l);
        return;
      end
      e = expected_q.pop_front();
      if (u !== e.ev || d[7:0] !== e.pb || d[11:8] !== e.opc || d[12] !== e.fin ||
          d[13 +: LEN_W] !== e.len || l !== e.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: ev %0d/%0d byte %h/%h opc %h/%h fin %b/%b len %h/%h last %b/%b",
                   e.ev, u, e.pb, d[7:0], e.opc, d[11:8], e.fin, d[12],
                   e.len, d[13 +: LEN_W], e.last, l);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               s_tvalid;
  logic               s_tready;
  logic [7:0]         s_tdata;
  logic               m_tvalid;
  logic               m_tready;
  logic [TDATA_W-1:0] m_tdata;
  logic [1:0]         m_tuser;
  logic               m_tlast;

  frame_scoreboard sb;
  bit              idle_en;
  int unsigned     bytes_sent;

  websocket_frame_deframer_unmask dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = 8'h00;
    m_tready = 1'b1;
    idle_en  = 1'b1;
    bytes_sent = 0;
    sb = new();
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_byte(s_tdata);
      if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser, m_tlast);
    end
  end

  // receiver backpressure
  initial begin
    forever begin
      @(negedge clk);
      if (idle_en && $urandom_range(0, 3) == 0) begin
        m_tready = 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end
      m_tready = 1'b1;
    end
  end

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("Verification failed");
    $finish;
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_byte(input logic [7:0] b);
    if (idle_en && $urandom_range(0, 4) == 0) begin
      s_tvalid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = b;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    bytes_sent++;
  endtask

  task automatic send_frame(input logic [7:0] hdr0, input len_enc_t enc,
                            input logic [63:0] len, input logic [31:0] key,
                            input bit rand_payload);
    logic [7:0] hdr1;
    case (enc)
      ENC_LEN7:  hdr1 = {1'b1, len[6:0]};
      ENC_LEN16: hdr1 = {1'b1, LEN7_EXT16};
      default:   hdr1 = {1'b1, LEN7_EXT64};
    endcase
    send_byte(hdr0);
    send_byte(hdr1);
    if (enc == ENC_LEN16) begin
      send_byte(len[15:8]);
      send_byte(len[7:0]);
    end else if (enc == ENC_LEN64) begin
      for (int i = 7; i >= 0; i--) send_byte(len[8 * i +: 8]);
    end
    for (int i = 3; i >= 0; i--) send_byte(key[8 * i +: 8]);
    for (longint unsigned p = 0; p < len; p++)
      send_byte(rand_payload ? 8'($urandom) : (p[0] ? 8'hFF : 8'h00));
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(negedge clk);
  endtask

  initial begin
    len_enc_t    enc;
    logic [63:0] len;
    int unsigned pick;
    int unsigned tail;

    repeat (10) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // short frame, all-ones key, FIN clear, opcode 0
    send_frame(8'h00, ENC_LEN7, 64'd2, 32'hFFFF_FFFF, 1'b0);
    // non-minimal 16-bit length, opcode 0xF, reserved bits set
    send_frame(8'hFF, ENC_LEN16, 64'd1, 32'hA55A_0FF0, 1'b0);
    // empty frame over a 64-bit length
    send_frame(8'h89, ENC_LEN64, 64'd0, 32'h0000_0000, 1'b0);

    // hold the sender until the output side has caught up
    s_tvalid = 1'b0;
    wait_drained();

    bytes_sent = 0;
    while (bytes_sent < RAND_BYTES) begin
      if (bytes_sent > CALM_AFTER) idle_en = 1'b0;
      pick = $urandom_range(0, 99);
      if (pick < 60) enc = ENC_LEN7;
      else if (pick < 85) enc = ENC_LEN16;
      else enc = ENC_LEN64;
      case (enc)
        ENC_LEN7:  len = ($urandom_range(0, 9) == 0) ? 64'($urandom_range(0, 125))
                                                      : 64'($urandom_range(0, 12));
        ENC_LEN16: len = ($urandom_range(0, 7) == 0) ? 64'($urandom_range(126, 300))
                                                      : 64'($urandom_range(0, 12));
        default:   len = 64'($urandom_range(0, 12));
      endcase
      send_frame(8'($urandom), enc, len, 32'($urandom), 1'b1);
    end

    // unmasked frame, then bytes that must be swallowed
    send_byte(8'($urandom));
    send_byte({1'b0, 7'($urandom)});
    tail = $urandom_range(4, 12);
    repeat (tail) send_byte(8'($urandom));
    s_tvalid = 1'b0;

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
